### design/hti_pkg.sv
// Shared types and constants for the tension/bias Hermite interpolator.
// Widths derive from the sample, fraction and register widths below.
// Used by every module of the block and by its checker.
package hti_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int FRAC_BITS    = 16;
   localparam int CFG_WIDTH    = 16;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TENSION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS    = CSR_IDX_W'(1);

   // tangent weights: (one +/- bias) * (one - tension), Q6.28 each
   localparam int GAIN_W = CFG_WIDTH + 1;
   localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) <<< (CFG_WIDTH - 2);
   localparam int WGT_W  = 2 * GAIN_W;
   localparam int WLO_W  = GAIN_W;
   localparam int WHI_W  = WGT_W - WLO_W;

   // tangent products
   localparam int DIFF_W    = SAMPLE_WIDTH + 1;
   localparam int TPL_W     = DIFF_W + WLO_W + 1;
   localparam int TPH_W     = DIFF_W + WHI_W;
   localparam int TPROD_W   = DIFF_W + WGT_W;
   localparam int TSUM_W    = TPROD_W + 1;
   localparam int TAN_SHIFT = 2 * (CFG_WIDTH - 2) + 1;
   localparam int TAN_W     = TSUM_W - TAN_SHIFT;
   localparam logic signed [TSUM_W-1:0] TSUM_HALF = TSUM_W'(1) <<< (TAN_SHIFT - 1);

   // basis functions
   localparam int U_W   = FRAC_BITS + 1;
   localparam logic [U_W-1:0] U_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam int U2_W  = 2 * U_W;
   localparam int U3R_W = U2_W + U_W;
   localparam logic [U3R_W-1:0] U3_HALF = U3R_W'(1) << (FRAC_BITS - 1);
   localparam int H_W   = 2 * FRAC_BITS + 3;
   localparam logic signed [H_W-1:0] H_ONE_SQ = H_W'(1) <<< (2 * FRAC_BITS);
   localparam int HLO_W = (H_W + 1) / 2;
   localparam int HHI_W = H_W - HLO_W;

   // blend products and final rounding
   localparam int BPL_W   = TAN_W + HLO_W + 1;
   localparam int BPH_W   = TAN_W + HHI_W;
   localparam int BPROD_W = TAN_W + H_W;
   localparam int ACC_W   = BPROD_W + 2;
   localparam int RES_W   = ACC_W - 2 * FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (2 * FRAC_BITS - 1);

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // four products per step: two tangent sums of two, a blend of four
   localparam int TERMS = 4;

   // queue between front and back
   localparam int Q_PTR_W = 1;
   localparam int Q_DEPTH = 1 << Q_PTR_W;
   localparam int QC_W    = Q_PTR_W + 1;

   // back-end register stages ahead of the output register
   localparam int PIPE_STAGES = 7;

   // items in flight: queue, stages and output register
   localparam int CNT_W = $clog2(Q_DEPTH + PIPE_STAGES + 2);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] seg_start;
      logic signed [SAMPLE_WIDTH-1:0] seg_end;
      logic signed [DIFF_W-1:0]       d_before;
      logic signed [DIFF_W-1:0]       d_mid;
      logic signed [DIFF_W-1:0]       d_after;
      logic signed [WGT_W-1:0]        wa;
      logic signed [WGT_W-1:0]        wb;
      logic        [U_W-1:0]          u;
   } hti_entry_type;

endpackage

### design/hti_front.sv
// Front end: tension/bias registers, input handshake, item classification.
// Forms sample differences, tangent weights and the clamped fraction.
// Depends on hti_pkg.
module hti_front import hti_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CFG_WIDTH-1:0]           csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_point_before,
   input  logic signed [SAMPLE_WIDTH-1:0] req_seg_start,
   input  logic signed [SAMPLE_WIDTH-1:0] req_seg_end,
   input  logic signed [SAMPLE_WIDTH-1:0] req_point_after,
   input  logic [U_W-1:0]                 req_fraction,
   input  logic                           q_full,
   output logic                           q_push,
   output hti_entry_type                  q_entry
);

   logic signed [CFG_WIDTH-1:0] tension_ff, tension_in;
   logic signed [CFG_WIDTH-1:0] bias_ff, bias_in;
   logic signed [GAIN_W-1:0]    gain_t, gain_a, gain_b;
   logic                        csr_write;

   assign csr_ready = ~reset;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      tension_in = tension_ff;
      bias_in    = bias_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TENSION: tension_in = csr_data;
            CSR_BIAS:    bias_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= '0;
         bias_ff    <= '0;
      end else begin
         tension_ff <= tension_in;
         bias_ff    <= bias_in;
      end
   end

   assign gain_t = GAIN_ONE - GAIN_W'(tension_ff);
   assign gain_a = GAIN_ONE + GAIN_W'(bias_ff);
   assign gain_b = GAIN_ONE - GAIN_W'(bias_ff);

   assign req_ready = ~q_full & ~reset;
   assign q_push    = req_valid & req_ready;

   always_comb begin
      q_entry.seg_start = req_seg_start;
      q_entry.seg_end   = req_seg_end;
      q_entry.d_before  = DIFF_W'(req_seg_start) - DIFF_W'(req_point_before);
      q_entry.d_mid     = DIFF_W'(req_seg_end) - DIFF_W'(req_seg_start);
      q_entry.d_after   = DIFF_W'(req_point_after) - DIFF_W'(req_seg_end);
      q_entry.wa        = gain_a * gain_t;
      q_entry.wb        = gain_b * gain_t;
      // anything past one counts as one
      q_entry.u         = (req_fraction > U_ONE) ? U_ONE : req_fraction;
   end

endmodule

### design/hti_queue.sv
// Two-entry queue of classified items between front and back end.
// Lets the front keep accepting while the back end is stalled.
// Depends on hti_pkg.
module hti_queue import hti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hti_entry_type entry_in,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output hti_entry_type entry_out
);

   hti_entry_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == QC_W'(Q_DEPTH));
   assign valid     = (count_ff != '0);
   assign entry_out = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(do_pop);
      count_in  = count_ff + QC_W'(do_push) - QC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### design/hti_back.sv
// Back end: tangent, basis and blend pipeline with saturation and output register.
// Tangent and blend multiplications are split in two partial products, summed in the next stage.
// Depends on hti_pkg.
module hti_back import hti_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  hti_entry_type                  q_entry,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_blended,
   output logic                           rsp_clipped
);

   logic                     adv;
   logic [PIPE_STAGES-1:0]   vld_ff, vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // stage 1: tangent partial products, u squared
   logic signed [DIFF_W-1:0]       op_d [TERMS];
   logic signed [WGT_W-1:0]        op_w [TERMS];
   logic signed [TPL_W-1:0]        tpl_ff [TERMS], tpl_in [TERMS];
   logic signed [TPH_W-1:0]        tph_ff [TERMS], tph_in [TERMS];
   logic [U2_W-1:0]                u2_s1_ff, u2_s1_in;
   logic [U_W-1:0]                 u_s1_ff;
   logic signed [SAMPLE_WIDTH-1:0] ps_s1_ff, pe_s1_ff;

   // stage 2: tangent products, u cubed unrounded
   logic signed [TPROD_W-1:0]      tprod_ff [TERMS], tprod_in [TERMS];
   logic [U3R_W-1:0]               u3r_ff, u3r_in;
   logic [U2_W-1:0]                u2_s2_ff;
   logic [U_W-1:0]                 u_s2_ff;
   logic signed [SAMPLE_WIDTH-1:0] ps_s2_ff, pe_s2_ff;

   // stage 3: rounded tangents and u cubed
   logic signed [TSUM_W-1:0]       tsum_in, tsum_out_in;
   logic signed [TAN_W-1:0]        tin_s3_ff, tin_s3_in, tout_s3_ff, tout_s3_in;
   logic [U3R_W-1:0]               u3_rnd;
   logic [H_W-1:0]                 u3_ff, u3_in;
   logic [U2_W-1:0]                u2_s3_ff;
   logic [U_W-1:0]                 u_s3_ff;
   logic signed [SAMPLE_WIDTH-1:0] ps_s3_ff, pe_s3_ff;

   // stage 4: basis weights
   logic signed [H_W-1:0]          u2_h, u3_h, us_h;
   logic signed [H_W-1:0]          h_ff [TERMS], h_in [TERMS];
   logic signed [TAN_W-1:0]        tin_s4_ff, tout_s4_ff;
   logic signed [SAMPLE_WIDTH-1:0] ps_s4_ff, pe_s4_ff;

   // stage 5..7: blend
   logic signed [TAN_W-1:0]        op_a [TERMS];
   logic signed [BPL_W-1:0]        bpl_ff [TERMS], bpl_in [TERMS];
   logic signed [BPH_W-1:0]        bph_ff [TERMS], bph_in [TERMS];
   logic signed [BPROD_W-1:0]      bprod_ff [TERMS], bprod_in [TERMS];
   logic signed [ACC_W-1:0]        bsum_ff [2], bsum_in [2];

   // output
   logic signed [ACC_W-1:0]        acc;
   logic signed [RES_W-1:0]        res;
   logic                           over_hi, over_lo;
   logic signed [SAMPLE_WIDTH-1:0] blended_ff, blended_in;
   logic                           clipped_ff, clipped_in;

   // whole pipeline holds while a result waits at the output
   assign adv   = ~rsp_valid_ff | rsp_ready;
   assign q_pop = adv & q_valid;

   assign vld_in       = {vld_ff[PIPE_STAGES-2:0], q_valid};
   assign rsp_valid_in = vld_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1
   always_comb begin
      op_d[0] = q_entry.d_before;  op_w[0] = q_entry.wa;
      op_d[1] = q_entry.d_mid;     op_w[1] = q_entry.wb;
      op_d[2] = q_entry.d_mid;     op_w[2] = q_entry.wa;
      op_d[3] = q_entry.d_after;   op_w[3] = q_entry.wb;
      for (int k = 0; k < TERMS; k++) begin
         tpl_in[k] = op_d[k] * $signed({1'b0, op_w[k][WLO_W-1:0]});
         tph_in[k] = op_d[k] * $signed(op_w[k][WGT_W-1:WLO_W]);
      end
      u2_s1_in = U2_W'(q_entry.u) * U2_W'(q_entry.u);
   end

   // stage 2
   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         tprod_in[k] = TPROD_W'(tpl_ff[k]) + (TPROD_W'(tph_ff[k]) <<< WLO_W);
      end
      u3r_in = U3R_W'(u2_s1_ff) * U3R_W'(u_s1_ff);
   end

   // stage 3: round half up on tangents and u cubed
   always_comb begin
      tsum_in     = TSUM_W'(tprod_ff[0]) + TSUM_W'(tprod_ff[1]) + TSUM_HALF;
      tsum_out_in = TSUM_W'(tprod_ff[2]) + TSUM_W'(tprod_ff[3]) + TSUM_HALF;
      tin_s3_in   = tsum_in[TAN_SHIFT +: TAN_W];
      tout_s3_in  = tsum_out_in[TAN_SHIFT +: TAN_W];
      u3_rnd      = u3r_ff + U3_HALF;
      u3_in       = H_W'(u3_rnd >> FRAC_BITS);
   end

   // stage 4: h00, h01, h10, h11
   always_comb begin
      u2_h    = $signed(H_W'(u2_s3_ff));
      u3_h    = $signed(u3_ff);
      us_h    = $signed(H_W'(u_s3_ff)) <<< FRAC_BITS;
      h_in[0] = (u3_h <<< 1) - (u2_h <<< 1) - u2_h + H_ONE_SQ;
      h_in[1] = (u2_h <<< 1) + u2_h - (u3_h <<< 1);
      h_in[2] = u3_h - (u2_h <<< 1) + us_h;
      h_in[3] = u3_h - u2_h;
   end

   // stage 5
   always_comb begin
      op_a[0] = TAN_W'(ps_s4_ff);
      op_a[1] = TAN_W'(pe_s4_ff);
      op_a[2] = tin_s4_ff;
      op_a[3] = tout_s4_ff;
      for (int k = 0; k < TERMS; k++) begin
         bpl_in[k] = op_a[k] * $signed({1'b0, h_ff[k][HLO_W-1:0]});
         bph_in[k] = op_a[k] * $signed(h_ff[k][H_W-1:HLO_W]);
      end
   end

   // stage 6 and 7
   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         bprod_in[k] = BPROD_W'(bpl_ff[k]) + (BPROD_W'(bph_ff[k]) <<< HLO_W);
      end
      bsum_in[0] = ACC_W'(bprod_ff[0]) + ACC_W'(bprod_ff[1]);
      bsum_in[1] = ACC_W'(bprod_ff[2]) + ACC_W'(bprod_ff[3]);
   end

   // final round half up and saturation
   always_comb begin
      acc     = bsum_ff[0] + bsum_ff[1] + ACC_HALF;
      res     = acc[2*FRAC_BITS +: RES_W];
      over_hi = res > RES_W'(SAMPLE_MAX);
      over_lo = res < RES_W'(SAMPLE_MIN);
      clipped_in = over_hi | over_lo;
      if (over_hi) begin
         blended_in = SAMPLE_MAX;
      end else if (over_lo) begin
         blended_in = SAMPLE_MIN;
      end else begin
         blended_in = res[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tpl_ff     <= tpl_in;
         tph_ff     <= tph_in;
         u2_s1_ff   <= u2_s1_in;
         u_s1_ff    <= q_entry.u;
         ps_s1_ff   <= q_entry.seg_start;
         pe_s1_ff   <= q_entry.seg_end;

         tprod_ff   <= tprod_in;
         u3r_ff     <= u3r_in;
         u2_s2_ff   <= u2_s1_ff;
         u_s2_ff    <= u_s1_ff;
         ps_s2_ff   <= ps_s1_ff;
         pe_s2_ff   <= pe_s1_ff;

         tin_s3_ff  <= tin_s3_in;
         tout_s3_ff <= tout_s3_in;
         u3_ff      <= u3_in;
         u2_s3_ff   <= u2_s2_ff;
         u_s3_ff    <= u_s2_ff;
         ps_s3_ff   <= ps_s2_ff;
         pe_s3_ff   <= pe_s2_ff;

         h_ff       <= h_in;
         tin_s4_ff  <= tin_s3_ff;
         tout_s4_ff <= tout_s3_ff;
         ps_s4_ff   <= ps_s3_ff;
         pe_s4_ff   <= pe_s3_ff;

         bpl_ff     <= bpl_in;
         bph_ff     <= bph_in;
         bprod_ff   <= bprod_in;
         bsum_ff    <= bsum_in;

         blended_ff <= blended_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_blended = blended_ff;
   assign rsp_clipped = clipped_ff;

endmodule

### design/hermite_tension_bias_interpolator_core.sv
// Cubic Hermite interpolator with tension and bias, one sample component per item.
//
// Channels: req_* carries four control samples (signed Q16.16) and a fraction
// (unsigned Q1.16, values above 1.0 act as 1.0); rsp_* returns the blended
// sample and a flag that is set when the blend saturated to the sample range.
// csr_* writes tension (index 0) and bias (index 1), both signed Q2.14;
// other indexes are ignored. Write them only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. Path: an
// accepted item passes through the queue, seven register stages of multiply
// and add, and the output register before its result becomes valid.
// When rsp_ready is low the result is held and the back-end pipeline stalls;
// the two-entry queue keeps taking items until it fills, then req_ready drops.
// Reset: tension and bias return to 0, queue and pipeline empty; req_ready and
// csr_ready are low while reset is asserted.
// Depends on hti_pkg, hti_front, hti_queue and hti_back.
module hermite_tension_bias_interpolator_core import hti_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CFG_WIDTH-1:0]           csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_point_before,
   input  logic signed [SAMPLE_WIDTH-1:0] req_seg_start,
   input  logic signed [SAMPLE_WIDTH-1:0] req_seg_end,
   input  logic signed [SAMPLE_WIDTH-1:0] req_point_after,
   input  logic [U_W-1:0]                 req_fraction,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_blended,
   output logic                           rsp_clipped
);

   logic          q_full, q_push, q_valid, q_pop;
   hti_entry_type push_entry, head_entry;

   hti_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_before (req_point_before),
      .req_seg_start    (req_seg_start),
      .req_seg_end      (req_seg_end),
      .req_point_after  (req_point_after),
      .req_fraction     (req_fraction),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   hti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .entry_out (head_entry)
   );

   hti_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (head_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_blended (rsp_blended),
      .rsp_clipped (rsp_clipped)
   );

endmodule

### design/hti_checker.sv
// Port-level checker for the interpolator core, attached by bind below.
// Tracks items in flight and checks result hold, saturation, reset,
// results without items and quiet csr writes. Depends on hti_pkg.
module hti_checker import hti_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_blended,
   input logic                           rsp_clipped
);

   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             req_take, rsp_take;

   assign req_take    = req_valid & req_ready;
   assign rsp_take    = rsp_valid & rsp_ready;
   assign inflight_in = inflight_ff + CNT_W'(req_take) - CNT_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blended) && $stable(rsp_clipped))
      else $error("stalled result changed or dropped");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_blended == SAMPLE_MAX || rsp_blended == SAMPLE_MIN)
      else $error("clipped result not at a range limit");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("result without an accepted item");

   a_csr_quiet: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> inflight_ff == '0)
      else $error("configuration write while items in flight");

endmodule

bind hermite_tension_bias_interpolator_core hti_checker u_hti_checker (.*);

### verif/hermite_tension_bias_interpolator_core_tb.sv
// Self-checking bench for hermite_tension_bias_interpolator_core: a directed
// table, then random phases under varied tension/bias, checked against an
// in-bench fixed-point Hermite predictor. Depends on hti_pkg and the core RTL.
module hermite_tension_bias_interpolator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hti_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 9;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;
   localparam int NUM_DIRECTED    = 21;
   localparam int NUM_FIXED       = 7;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 150;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] point_before;
      logic [SAMPLE_WIDTH-1:0] seg_start;
      logic [SAMPLE_WIDTH-1:0] seg_end;
      logic [SAMPLE_WIDTH-1:0] point_after;
      logic [U_W-1:0]          fraction;
      logic                    typed;
      logic [SAMPLE_WIDTH-1:0] want_blended;
      logic                    want_clipped;
   } sample_set_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] blended;
      logic                    clipped;
   } blend_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_WIDTH-1:0] csr_data;
   logic req_valid;
   logic req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_point_before;
   logic signed [SAMPLE_WIDTH-1:0] req_seg_start;
   logic signed [SAMPLE_WIDTH-1:0] req_seg_end;
   logic signed [SAMPLE_WIDTH-1:0] req_point_after;
   logic [U_W-1:0] req_fraction;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SAMPLE_WIDTH-1:0] rsp_blended;
   logic rsp_clipped;

   logic signed [CFG_WIDTH-1:0] tension_cfg = '0;
   logic signed [CFG_WIDTH-1:0] bias_cfg = '0;
   blend_result_type pending_blends[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit rsp_stalls = 1'b0;

   logic [CFG_WIDTH-1:0] fixed_tension [NUM_FIXED] =
      '{16'h0000, 16'h4000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hC000};
   logic [CFG_WIDTH-1:0] fixed_bias [NUM_FIXED] =
      '{16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h2000};

   // typed rows assume tension and bias at their reset value of zero
   sample_set_type directed_sets [NUM_DIRECTED] = '{
      '{32'h0, 32'h0, 32'h0, 32'h0, 17'h00000, 1'b1, 32'h0, 1'b0},
      '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 17'h00000, 1'b1, SAMPLE_MAX, 1'b0},
      '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 17'h00000, 1'b1, SAMPLE_MIN, 1'b0},
      '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 17'h10000, 1'b1, SAMPLE_MIN, 1'b0},
      '{32'h12345678, 32'hFFFFFFFB, 32'h70000000, SAMPLE_MIN, 17'h1FFFF,
        1'b1, 32'h70000000, 1'b0},
      '{32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h0, 17'h10001, 1'b1, 32'hFFFF0000, 1'b0},
      '{32'hDEADBEEF, 32'hDEADBEEF, 32'hDEADBEEF, 32'hDEADBEEF, 17'h08000,
        1'b1, 32'hDEADBEEF, 1'b0},
      '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 17'h00001, 1'b1, SAMPLE_MAX, 1'b0},
      '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 17'h0FFFF, 1'b1, SAMPLE_MIN, 1'b0},
      '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 17'h08000, 1'b1, SAMPLE_MAX, 1'b1},
      '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 17'h08000, 1'b1, SAMPLE_MIN, 1'b1},
      '{32'h0, 32'h00010000, 32'h00020000, 32'h00030000, 17'h08000, 1'b0, 32'h0, 1'b0},
      '{32'h0, 32'hFFFF0000, 32'hFFFE0000, 32'hFFFD0000, 17'h00001, 1'b0, 32'h0, 1'b0},
      '{32'h01234567, 32'h89ABCDEF, 32'h76543210, 32'hFEDCBA98, 17'h0FFFF, 1'b0, 32'h0, 1'b0},
      '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 17'h04000, 1'b0, 32'h0, 1'b0},
      '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 17'h0C000, 1'b0, 32'h0, 1'b0},
      '{32'h1, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 17'h08000, 1'b0, 32'h0, 1'b0},
      '{32'hFFFFFFFF, 32'h0, 32'h0, 32'h1, 17'h05555, 1'b0, 32'h0, 1'b0},
      '{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 17'h15555, 1'b0, 32'h0, 1'b0},
      '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 17'h0AAAA, 1'b0, 32'h0, 1'b0},
      '{32'h0, SAMPLE_MAX, SAMPLE_MIN, 32'h0, 17'h02000, 1'b0, 32'h0, 1'b0}
   };

   hermite_tension_bias_interpolator_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_before (req_point_before),
      .req_seg_start    (req_seg_start),
      .req_seg_end      (req_seg_end),
      .req_point_after  (req_point_after),
      .req_fraction     (req_fraction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_blended      (rsp_blended),
      .rsp_clipped      (rsp_clipped)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // add half an LSB, then shift right arithmetically
   function automatic wide_type round_half_up(input wide_type value, input int shift);
      wide_type half;
      half = wide_type'(1) <<< (shift - 1);
      return (value + half) >>> shift;
   endfunction

   function automatic blend_result_type hermite_blend(input sample_set_type set);
      wide_type ten, bs, q14_one, tm, wa, wb;
      wide_type ps, pe, d_before, d_mid, d_after, t_in, t_out;
      wide_type one_f, u, u2, u3, h00, h10, h11, h01, total;
      blend_result_type res;
      ten = wide_type'(tension_cfg);
      bs = wide_type'(bias_cfg);
      q14_one = wide_type'(1) <<< (CFG_WIDTH - 2);
      tm = q14_one - ten;
      wa = (q14_one + bs) * tm;
      wb = (q14_one - bs) * tm;
      ps = wide_type'($signed(set.seg_start));
      pe = wide_type'($signed(set.seg_end));
      d_before = ps - wide_type'($signed(set.point_before));
      d_mid = pe - ps;
      d_after = wide_type'($signed(set.point_after)) - pe;
      t_in = round_half_up(d_before * wa + d_mid * wb, TAN_SHIFT);
      t_out = round_half_up(d_mid * wa + d_after * wb, TAN_SHIFT);
      one_f = wide_type'(1) <<< FRAC_BITS;
      u = '0;
      u[U_W-1:0] = set.fraction;
      if (u > one_f) u = one_f;
      u2 = u * u;
      u3 = round_half_up(u2 * u, FRAC_BITS);
      h00 = 2 * u3 - 3 * u2 + one_f * one_f;
      h10 = u3 - 2 * u2 + u * one_f;
      h11 = u3 - u2;
      h01 = 3 * u2 - 2 * u3;
      total = round_half_up(ps * h00 + pe * h01 + t_in * h10 + t_out * h11, 2 * FRAC_BITS);
      res.clipped = 1'b1;
      if (total > wide_type'(SAMPLE_MAX)) res.blended = SAMPLE_MAX;
      else if (total < wide_type'(SAMPLE_MIN)) res.blended = SAMPLE_MIN;
      else begin
         res.blended = total[SAMPLE_WIDTH-1:0];
         res.clipped = 1'b0;
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] corner_sample();
      case ($urandom_range(0, 4))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TENSION: tension_cfg = value;
         CSR_BIAS: bias_cfg = value;
         default: ;
      endcase
      repeat ($urandom_range(1, 4)) @(posedge clock);
   endtask

   task automatic send_set(input sample_set_type set, input bit allow_gaps);
      int gap;
      blend_result_type want;
      gap = allow_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_before <= set.point_before;
      req_seg_start <= set.seg_start;
      req_seg_end <= set.seg_end;
      req_point_after <= set.point_after;
      req_fraction <= set.fraction;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (set.typed) begin
         want.blended = set.want_blended;
         want.clipped = set.want_clipped;
      end else begin
         want = hermite_blend(set);
      end
      pending_blends.push_back(want);
   endtask

   task automatic drain_pipeline();
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: ready runs and stalls, stalls only while enabled
   initial begin
      int hold;
      bit level;
      forever begin
         level = !rsp_stalls || ($urandom_range(0, 2) != 0);
         if (level) hold = $urandom_range(1, 8);
         else hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
         rsp_ready <= level;
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      blend_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_blends.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result with nothing pending: blended %h clipped %b",
                        rsp_blended, rsp_clipped);
         end else begin
            want = pending_blends.pop_front();
            if (rsp_blended !== want.blended || rsp_clipped !== want.clipped) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: blended exp %h got %h, clipped exp %b got %b",
                           want.blended, rsp_blended, want.clipped, rsp_clipped);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int i, phase, n, kind;
      bit req_gaps;
      sample_set_type set;
      logic [CFG_WIDTH-1:0] ten, bs;
      logic [CSR_IDX_W-1:0] spare;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_TENSION;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_point_before <= '0;
      req_seg_start <= '0;
      req_seg_end <= '0;
      req_point_after <= '0;
      req_fraction <= '0;
      rsp_stalls = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) send_set(directed_sets[i], 1'b1);
      req_valid <= 1'b0;

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_pipeline();
         if (phase < NUM_FIXED) begin
            ten = fixed_tension[phase];
            bs = fixed_bias[phase];
         end else begin
            ten = CFG_WIDTH'($urandom);
            bs = CFG_WIDTH'($urandom);
         end
         // unmapped index goes in at a random spot; it must change nothing
         spare = $urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3;
         kind = $urandom_range(0, 2);
         if (kind == 0) write_csr(spare, CFG_WIDTH'($urandom));
         write_csr(CSR_TENSION, ten);
         if (kind == 1) write_csr(spare, CFG_WIDTH'($urandom));
         write_csr(CSR_BIAS, bs);
         if (kind == 2) write_csr(spare, CFG_WIDTH'($urandom));

         req_gaps = $urandom_range(0, 2) != 0;
         rsp_stalls = $urandom_range(0, 2) != 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            set = '0;
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               // smooth run: neighbors close together
               set.point_before = $urandom;
               set.seg_start = set.point_before + $urandom_range(0, 32'h20_0000) - 32'h10_0000;
               set.seg_end = set.seg_start + $urandom_range(0, 32'h20_0000) - 32'h10_0000;
               set.point_after = set.seg_end + $urandom_range(0, 32'h20_0000) - 32'h10_0000;
            end else if (kind < 6) begin
               set.point_before = $urandom;
               set.seg_start = $urandom;
               set.seg_end = $urandom;
               set.point_after = $urandom;
            end else if (kind == 6) begin
               set.point_before = corner_sample();
               set.seg_start = corner_sample();
               set.seg_end = corner_sample();
               set.point_after = corner_sample();
            end else begin
               set.point_before = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
               set.seg_start = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
               set.seg_end = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
               set.point_after = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
            end
            kind = $urandom_range(0, 19);
            if (kind == 0) set.fraction = '0;
            else if (kind == 1) set.fraction = U_ONE;
            else if (kind == 2) set.fraction = U_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
            else set.fraction = U_W'($urandom_range(0, 32'h1_0000));
            send_set(set, req_gaps);
         end
         req_valid <= 1'b0;
      end

      drain_pipeline();
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
design/hti_pkg.sv
design/hti_front.sv
design/hti_queue.sv
design/hti_back.sv
design/hermite_tension_bias_interpolator_core.sv
design/hti_checker.sv
verif/hermite_tension_bias_interpolator_core_tb.sv
